>>> sv/bgrpi_pkg.sv
package bgrpi_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;

  localparam int COLOUR_W = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 2'd1;

  localparam logic [7:0] ALPHA_THR_RST = 8'd0;
  localparam logic [2:0] CHAN_CNT_RST  = 3'd4;

  // item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_MAP    = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  // byte layouts; anything else is rgba
  localparam logic [2:0] CH_GRAY       = 3'd1;
  localparam logic [2:0] CH_GRAY_ALPHA = 3'd2;
  localparam logic [2:0] CH_RGB        = 3'd3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] entry_number;
  } bgrpi_req_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] packed_colour;
    logic [7:0]          palette_index;
    logic                found;
    logic [8:0]          set_size;
    logic                overflowed;
  } bgrpi_rsp_t;

  function automatic logic [COLOUR_W-1:0] pack_pixel(
    input logic [7:0] b0,
    input logic [7:0] b1,
    input logic [7:0] b2,
    input logic [7:0] b3,
    input logic [2:0] chan_cnt,
    input logic [7:0] alpha_thr
  );
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    r = b0;
    case (chan_cnt)
      CH_GRAY: begin
        g = b0; b = b0; a = ALPHA_OPAQUE;
      end
      CH_GRAY_ALPHA: begin
        g = b0; b = b0; a = b1;
      end
      CH_RGB: begin
        g = b1; b = b2; a = ALPHA_OPAQUE;
      end
      default: begin
        g = b1; b = b2; a = b3;
      end
    endcase
    if (a < alpha_thr) begin
      pack_pixel = '0;
    end else begin
      pack_pixel = {b[7:3], g[7:3], r[7:3]};
    end
  endfunction

endpackage

>>> sv/bgrpi_ram.sv
module bgrpi_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/bgr555_palette_indexer_top.sv
// Channel   Signals                              Direction  Beat
// req       req_valid, req_ready, req            in         one pixel / command
// rsp       rsp_valid, rsp_ready, rsp            out        one result
// cfg       cfg_valid, cfg_ready, cfg_index/data in         one register write
//
// One item at a time; req_ready is high only while the sequencer is idle.
// A map or insert runs a binary search over the sorted palette, each step a
// registered RAM read at the midpoint followed by a compare. An insert that
// misses then shifts the entries from its rank upward, one entry per cycle
// through the RAM port, and writes the new colour at that rank.
// Synchronous active-high reset clears set size, overflow flag and config;
// palette RAM contents are not cleared. A stalled rsp only holds the last step.
module bgr555_palette_indexer_top
  import bgrpi_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  bgrpi_req_t            req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output bgrpi_rsp_t            rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);  // holds the full depth
  localparam int WW = (CW > 9) ? CW : 9;          // common compare/mask width
  localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;  // issue read at midpoint, or at final rank
  localparam logic [2:0] ST_SWAIT  = 3'd2;  // compare midpoint entry
  localparam logic [2:0] ST_CHECK  = 3'd3;  // compare entry at final rank
  localparam logic [2:0] ST_MISS   = 3'd4;  // colour absent
  localparam logic [2:0] ST_SHIFT  = 3'd5;  // move entries up, then insert
  localparam logic [2:0] ST_RWAIT  = 3'd6;  // palette read data
  localparam logic [2:0] ST_FINISH = 3'd7;  // hand result to output reg

  logic [2:0]          state;
  logic [7:0]          alpha_thr;
  logic [2:0]          chan_cnt;
  logic [CW-1:0]       count;
  logic                ovf;
  logic [1:0]          kind;
  logic [COLOUR_W-1:0] colour;
  logic [CW-1:0]       lo;
  logic [CW-1:0]       hi;
  logic [CW-1:0]       mid_q;
  logic [CW-1:0]       k;
  logic                rd_pend;
  logic [CW-1:0]       rd_addr_q;
  logic [COLOUR_W-1:0] res_colour;
  logic [7:0]          res_index;
  logic                res_found;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [COLOUR_W-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [COLOUR_W-1:0] ram_rdata;

  logic [CW-1:0]       mid;
  logic [COLOUR_W-1:0] pix_colour;
  logic [WW-1:0]       entry_w;
  logic [WW-1:0]       count_w;
  logic [WW-1:0]       lo_w;
  logic [CW-1:0]       rd_addr_inc;

  assign mid         = lo + ((hi - lo) >> 1);
  assign pix_colour  = pack_pixel(req.byte0, req.byte1, req.byte2, req.byte3,
                                  chan_cnt, alpha_thr);
  assign entry_w     = WW'(req.entry_number);
  assign count_w     = WW'(count);
  assign lo_w        = WW'(lo);
  assign rd_addr_inc = rd_addr_q + 1'b1;

  assign req_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // RAM port steering
  always_comb begin
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = rd_pend ? rd_addr_inc[AW-1:0] : lo[AW-1:0];
    ram_wdata = rd_pend ? ram_rdata : colour;
    case (state)
      ST_IDLE: begin
        ram_raddr = entry_w[AW-1:0];
      end
      ST_SEARCH: begin
        ram_raddr = (lo < hi) ? mid[AW-1:0] : lo[AW-1:0];
      end
      ST_SHIFT: begin
        ram_raddr = k[AW-1:0] - 1'b1;
        ram_we    = rd_pend || (k == lo);
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  bgrpi_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_thr <= ALPHA_THR_RST;
      chan_cnt  <= CHAN_CNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ALPHA_THRESHOLD: alpha_thr <= cfg_data;
        CFG_CHANNEL_COUNT:   chan_cnt  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // the finishing step reloads valid itself
      if (rsp_valid && rsp_ready && state != ST_FINISH) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            kind       <= req.kind;
            colour     <= pix_colour;
            lo         <= '0;
            hi         <= count;
            res_colour <= pix_colour;
            res_index  <= '0;
            res_found  <= 1'b0;
            case (req.kind)
              KIND_CLEAR: begin
                count      <= '0;
                ovf        <= 1'b0;
                res_colour <= '0;
                state      <= ST_FINISH;
              end
              KIND_READ: begin
                res_index <= req.entry_number;
                if (entry_w < count_w) begin
                  state <= ST_RWAIT;
                end else begin
                  res_colour <= '0;
                  state      <= ST_FINISH;
                end
              end
              default: begin
                state <= ST_SEARCH;
              end
            endcase
          end
        end
        ST_SEARCH: begin
          mid_q <= mid;
          if (lo < hi) begin
            state <= ST_SWAIT;
          end else if (lo < count) begin
            state <= ST_CHECK;
          end else begin
            state <= ST_MISS;
          end
        end
        ST_SWAIT: begin
          if (ram_rdata < colour) begin
            lo <= mid_q + 1'b1;
          end else begin
            hi <= mid_q;
          end
          state <= ST_SEARCH;
        end
        ST_CHECK: begin
          if (ram_rdata == colour) begin
            res_found <= 1'b1;
            res_index <= lo_w[7:0];
            state     <= ST_FINISH;
          end else begin
            state <= ST_MISS;
          end
        end
        ST_MISS: begin
          if (kind == KIND_INSERT && count < DEPTH_C) begin
            k       <= count;
            rd_pend <= 1'b0;
            state   <= ST_SHIFT;
          end else begin
            if (kind == KIND_INSERT) begin
              ovf <= 1'b1;
            end
            state <= ST_FINISH;
          end
        end
        ST_SHIFT: begin
          // read k-1 while the previous read lands at its address + 1
          if (k != lo) begin
            rd_pend   <= 1'b1;
            rd_addr_q <= k - 1'b1;
            k         <= k - 1'b1;
          end else if (rd_pend) begin
            rd_pend <= 1'b0;
          end else begin
            count     <= count + 1'b1;
            res_found <= 1'b1;
            res_index <= lo_w[7:0];
            state     <= ST_FINISH;
          end
        end
        ST_RWAIT: begin
          res_colour <= ram_rdata;
          res_found  <= 1'b1;
          state      <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register, loaded on the finishing step
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!rsp_valid || rsp_ready)) begin
      rsp.packed_colour <= res_colour;
      rsp.palette_index <= res_index;
      rsp.found         <= res_found;
      rsp.set_size      <= count_w[8:0];
      rsp.overflowed    <= ovf;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("set size above palette depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> count == DEPTH_C)
    else $error("overflow flag set while set not full");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |-> lo <= hi && hi <= count)
    else $error("search bounds crossed");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT |-> lo <= k && k <= count)
    else $error("shift pointer out of range");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.kind == KIND_CLEAR |=> count == '0 && !ovf)
    else $error("clear did not empty the set");

endmodule
